>>> rtl/core/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PAKF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pakf assertion failed");

// next-cycle implication
`define PAKF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pakf assertion failed");

`endif

>>> rtl/core/pakf_pkg.sv
package pakf_pkg;

  localparam int NUM_JOINTS_DEF    = 12;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int CW  = 27;
  localparam int DW  = 31;
  localparam int JW  = 5;

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0] PI16_Q13    = 16'sd25736;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q24 = 27'sd10188014;
  localparam logic [15:0] LINK_LENGTH_RST = 16'd2731;
  localparam logic [JW-1:0] JOINT_COUNT_MAX = 5'd31;

  typedef struct packed {
    logic signed [15:0] a;
    logic               last;
    logic               flip;
  } pakf_csb_t;

  typedef struct packed {
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic               neg;
    logic               cnt_err;
    logic [JW-1:0]      n;
  } pakf_dsb_t;

  function automatic logic signed [CW-1:0] atan_q24(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 27'sd13176795;
      1:  v = 27'sd7778716;
      2:  v = 27'sd4110060;
      3:  v = 27'sd2086331;
      4:  v = 27'sd1047214;
      5:  v = 27'sd524117;
      6:  v = 27'sd262123;
      7:  v = 27'sd131069;
      8:  v = 27'sd65536;
      9:  v = 27'sd32768;
      10: v = 27'sd16384;
      11: v = 27'sd8192;
      12: v = 27'sd4096;
      13: v = 27'sd2048;
      14: v = 27'sd1024;
      15: v = 27'sd512;
      16: v = 27'sd256;
      17: v = 27'sd128;
      18: v = 27'sd64;
      19: v = 27'sd32;
      20: v = 27'sd16;
      21: v = 27'sd8;
      22: v = 27'sd4;
      23: v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/pakf_channels.sv
interface pakf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] joint_angle;
  logic               last_joint;
  modport source (output valid, joint_angle, last_joint, input ready);
  modport sink (input valid, joint_angle, last_joint, output ready);
endinterface

interface pakf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] effector_x;
  logic signed [15:0] effector_y;
  logic signed [23:0] fitness;
  logic               count_error;
  modport source (output valid, effector_x, effector_y, fitness, count_error, input ready);
  modport sink (input valid, effector_x, effector_y, fitness, count_error, output ready);
endinterface

interface pakf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] link_length;
  modport source (output valid, link_length, input ready);
  modport sink (input valid, link_length, output ready);
endinterface

>>> rtl/core/pakf_cordic_cell.sv
module pakf_cordic_cell
  import pakf_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  input  pakf_csb_t            sb_in,
  output logic                 vld_out,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [CW-1:0] z_out,
  output pakf_csb_t            sb_out
);

  localparam logic signed [CW-1:0] ANGLE = atan_q24(IDX);

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic                 vld_r;
  logic signed [CW-1:0] x_r, y_r, z_r;
  pakf_csb_t            sb_r;

  always_comb begin
    dx = y_in >>> IDX;
    dy = x_in >>> IDX;
    if (!z_in[CW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ANGLE;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      sb_r <= sb_in;
    end
  end

  assign vld_out = vld_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;
  assign sb_out  = sb_r;

endmodule

>>> rtl/core/pakf_div_cell.sv
module pakf_div_cell
  import pakf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [JW-1:0] rem_in,
  input  logic [DW-1:0] dvd_in,
  input  pakf_dsb_t     sb_in,
  output logic          vld_out,
  output logic [JW-1:0] rem_out,
  output logic [DW-1:0] dvd_out,
  output pakf_dsb_t     sb_out
);

  logic [JW:0]   trial;
  logic          ge;
  logic [JW-1:0] rem_nxt;
  logic [DW-1:0] dvd_nxt;
  logic          vld_r;
  logic [JW-1:0] rem_r;
  logic [DW-1:0] dvd_r;
  pakf_dsb_t     sb_r;

  always_comb begin
    trial   = {rem_in, dvd_in[DW-1]};
    ge      = trial >= {1'b0, sb_in.n};
    rem_nxt = ge ? JW'(trial - {1'b0, sb_in.n}) : trial[JW-1:0];
    dvd_nxt = {dvd_in[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      sb_r  <= sb_in;
    end
  end

  assign vld_out = vld_r;
  assign rem_out = rem_r;
  assign dvd_out = dvd_r;
  assign sb_out  = sb_r;

endmodule

>>> rtl/core/planar_arm_kinematics_fitness_core.sv
// Planar arm forward kinematics and angle-spread fitness. Joint angles stream in one per
// cycle while the pipeline advances; each is added to a wrapped running angle, turned
// into cos and sin by a chain of CORDIC_STAGES rotation cells (capped at ATAN_ENTRIES),
// and summed. An item with last_joint set produces one result transaction on out_chan.
// The result carries scaled x and y, the fitness and a joint-count flag. The fitness
// quotient comes from a 31-cell restoring divider chain. Throughput is one item per cycle
// while the pipeline advances, bounded by the running-angle add; the pipeline only halts
// when a result is due while the previous one has not been taken.
`include "assert_macros.svh"

module planar_arm_kinematics_fitness_core
  import pakf_pkg::*;
#(
  parameter int NUM_JOINTS    = NUM_JOINTS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pakf_in_if.sink    in_chan,
  pakf_out_if.source out_chan,
  pakf_cfg_if.sink   cfg_chan
);

  localparam int CS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  logic adv, accept;

  // configuration
  logic [15:0] link_r;
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= LINK_LENGTH_RST;
    end else if (cfg_chan.valid) begin
      link_r <= cfg_chan.link_length;
    end
  end

  // running angle
  logic signed [15:0] running_r;
  logic signed [17:0] rsum;
  logic signed [15:0] r_nxt;
  logic               v0_r;
  logic signed [15:0] th0_r, a0_r;
  logic               last0_r;

  assign accept = in_chan.valid && adv;
  assign in_chan.ready = adv;

  always_comb begin
    rsum = {{2{running_r[15]}}, running_r} + {{2{in_chan.joint_angle[15]}}, in_chan.joint_angle};
    if (rsum >= PI_Q13) begin
      r_nxt = 16'(rsum - TWO_PI_Q13);
    end else if (rsum < -PI_Q13) begin
      r_nxt = 16'(rsum + TWO_PI_Q13);
    end else begin
      r_nxt = rsum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      v0_r      <= 1'b0;
    end else if (adv) begin
      v0_r <= in_chan.valid;
      if (in_chan.valid) begin
        running_r <= in_chan.last_joint ? 16'sd0 : r_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      th0_r   <= r_nxt;
      a0_r    <= in_chan.joint_angle;
      last0_r <= in_chan.last_joint;
    end
  end

  // quadrant fold
  logic               vp_r;
  logic signed [15:0] thf;
  logic               flip;
  logic signed [CW-1:0] zp_r;
  pakf_csb_t          sbp_r;

  always_comb begin
    flip = 1'b0;
    thf  = th0_r;
    if (th0_r > HALF_PI_Q13) begin
      thf  = th0_r - PI16_Q13;
      flip = 1'b1;
    end else if (th0_r < -HALF_PI_Q13) begin
      thf  = th0_r + PI16_Q13;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (adv) begin
      vp_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zp_r  <= {thf, 11'd0};
      sbp_r <= '{a: a0_r, last: last0_r, flip: flip};
    end
  end

  // rotation chain
  logic                 cv  [0:CS];
  logic signed [CW-1:0] cx  [0:CS];
  logic signed [CW-1:0] cy  [0:CS];
  logic signed [CW-1:0] cz  [0:CS];
  pakf_csb_t            csb [0:CS];

  assign cv[0]  = vp_r;
  assign cx[0]  = CORDIC_GAIN_Q24;
  assign cy[0]  = '0;
  assign cz[0]  = zp_r;
  assign csb[0] = sbp_r;

  for (genvar i = 0; i < CS; i++) begin : g_rot
    pakf_cordic_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .vld_in  (cv[i]),
      .x_in    (cx[i]),
      .y_in    (cy[i]),
      .z_in    (cz[i]),
      .sb_in   (csb[i]),
      .vld_out (cv[i+1]),
      .x_out   (cx[i+1]),
      .y_out   (cy[i+1]),
      .z_out   (cz[i+1]),
      .sb_out  (csb[i+1])
    );
  end

  // rounding, sign restore, square
  logic signed [CW-1:0] xr, yr;
  logic signed [16:0]   cq, sq;
  logic signed [31:0]   a_sq;
  logic                 v1_r, last1_r;
  logic signed [16:0]   c1_r, s1_r;
  logic signed [15:0]   a1_r;
  logic [30:0]          sq1_r;

  always_comb begin
    xr   = (cx[CS] + 27'sd512) >>> 10;
    yr   = (cy[CS] + 27'sd512) >>> 10;
    cq   = csb[CS].flip ? -xr[16:0] : xr[16:0];
    sq   = csb[CS].flip ? -yr[16:0] : yr[16:0];
    a_sq = csb[CS].a * csb[CS].a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= cv[CS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r    <= cq;
      s1_r    <= sq;
      a1_r    <= csb[CS].a;
      sq1_r   <= a_sq[30:0];
      last1_r <= csb[CS].last;
    end
  end

  // per-arm sums
  logic signed [19:0] cos_r, sin_r, ang_r;
  logic [33:0]        sqt_r;
  logic [JW-1:0]      cnt_r;
  logic signed [19:0] cos_nxt, sin_nxt, ang_nxt;
  logic [33:0]        sqt_nxt;
  logic [JW-1:0]      cnt_nxt;
  logic               v2_r;
  logic signed [19:0] cos2_r, sin2_r, ang2_r;
  logic [33:0]        sqt2_r;
  logic [JW-1:0]      n2_r;

  always_comb begin
    cos_nxt = cos_r + {{3{c1_r[16]}}, c1_r};
    sin_nxt = sin_r + {{3{s1_r[16]}}, s1_r};
    ang_nxt = ang_r + {{4{a1_r[15]}}, a1_r};
    sqt_nxt = sqt_r + {3'd0, sq1_r};
    cnt_nxt = (cnt_r == JOINT_COUNT_MAX) ? cnt_r : cnt_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= '0;
      sin_r <= '0;
      ang_r <= '0;
      sqt_r <= '0;
      cnt_r <= '0;
      v2_r  <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r && last1_r;
      if (v1_r) begin
        if (last1_r) begin
          cos_r <= '0;
          sin_r <= '0;
          ang_r <= '0;
          sqt_r <= '0;
          cnt_r <= '0;
        end else begin
          cos_r <= cos_nxt;
          sin_r <= sin_nxt;
          ang_r <= ang_nxt;
          sqt_r <= sqt_nxt;
          cnt_r <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos2_r <= cos_nxt;
      sin2_r <= sin_nxt;
      ang2_r <= ang_nxt;
      sqt2_r <= sqt_nxt;
      n2_r   <= cnt_nxt;
    end
  end

  // products
  logic               v3_r;
  logic signed [36:0] exp3_r, eyp3_r;
  logic [38:0]        nsq3_r;
  logic signed [39:0] asq3_r;
  logic [JW-1:0]      n3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      exp3_r <= $signed({1'b0, link_r}) * cos2_r;
      eyp3_r <= $signed({1'b0, link_r}) * sin2_r;
      nsq3_r <= n2_r * sqt2_r;
      asq3_r <= ang2_r * ang2_r;
      n3_r   <= n2_r;
    end
  end

  // position scaling and fitness numerator
  logic signed [36:0] exs, eys;
  logic signed [15:0] exc, eyc;
  logic signed [40:0] num;
  logic               v4_r;
  logic signed [15:0] ex4_r, ey4_r;
  logic signed [40:0] num4_r;
  logic [JW-1:0]      n4_r;

  always_comb begin
    exs = (exp3_r + 37'sd16384) >>> 15;
    eys = (eyp3_r + 37'sd16384) >>> 15;
    if (exs > 37'sd32767) begin
      exc = 16'sh7fff;
    end else if (exs < -37'sd32768) begin
      exc = -16'sh8000;
    end else begin
      exc = exs[15:0];
    end
    if (eys > 37'sd32767) begin
      eyc = 16'sh7fff;
    end else if (eys < -37'sd32768) begin
      eyc = -16'sh8000;
    end else begin
      eyc = eys[15:0];
    end
    num = $signed({2'b00, nsq3_r}) - $signed({1'b0, asq3_r[38:0]})
        + $signed({27'd0, n3_r, 9'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex4_r  <= exc;
      ey4_r  <= eyc;
      num4_r <= num;
      n4_r   <= n3_r;
    end
  end

  // magnitude for floor division
  logic signed [30:0] t5;
  logic signed [31:0] mag;
  logic               v5_r;
  logic [DW-1:0]      mag5_r;
  pakf_dsb_t          sb5_r;

  always_comb begin
    t5  = num4_r[40:10];
    mag = t5[30] ? ($signed({27'd0, n4_r}) - 32'sd1 - {t5[30], t5}) : {t5[30], t5};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag5_r <= mag[DW-1:0];
      sb5_r  <= '{ex: ex4_r, ey: ey4_r, neg: t5[30],
                  cnt_err: (n4_r != JW'(NUM_JOINTS)), n: n4_r};
    end
  end

  // divider chain
  logic          dv   [0:DW];
  logic [JW-1:0] drem [0:DW];
  logic [DW-1:0] ddvd [0:DW];
  pakf_dsb_t     dsb  [0:DW];

  assign dv[0]   = v5_r;
  assign drem[0] = '0;
  assign ddvd[0] = mag5_r;
  assign dsb[0]  = sb5_r;

  for (genvar j = 0; j < DW; j++) begin : g_div
    pakf_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .vld_in  (dv[j]),
      .rem_in  (drem[j]),
      .dvd_in  (ddvd[j]),
      .sb_in   (dsb[j]),
      .vld_out (dv[j+1]),
      .rem_out (drem[j+1]),
      .dvd_out (ddvd[j+1]),
      .sb_out  (dsb[j+1])
    );
  end

  // output register
  logic               out_valid_r;
  logic signed [15:0] ox_r, oy_r;
  logic signed [23:0] ofit_r;
  logic               oerr_r;
  logic [DW-1:0]      quot;
  logic signed [23:0] fit;

  assign adv  = !(out_valid_r && !out_chan.ready && dv[DW]);
  assign quot = ddvd[DW];

  always_comb begin
    if (dsb[DW].neg) begin
      fit = (quot > 31'd8388607) ? 24'sh7fffff : $signed(quot[23:0]);
    end else begin
      fit = (quot > 31'd8388608) ? 24'sh800000 : $signed(24'(-quot));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv[DW] || (out_valid_r && !out_chan.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dv[DW]) begin
      ox_r   <= dsb[DW].ex;
      oy_r   <= dsb[DW].ey;
      ofit_r <= fit;
      oerr_r <= dsb[DW].cnt_err;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.effector_x  = ox_r;
  assign out_chan.effector_y  = oy_r;
  assign out_chan.fitness     = ofit_r;
  assign out_chan.count_error = oerr_r;

  `PAKF_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_chan.ready)
  `PAKF_ASSERT_IMP(a_angle_range, 1'b1, (running_r >= -PI16_Q13) && (running_r < PI16_Q13))
  `PAKF_ASSERT_NXT(a_angle_cleared, accept && in_chan.last_joint, running_r == 16'sd0)
  `PAKF_ASSERT_NXT(a_sums_cleared, adv && v1_r && last1_r, (cnt_r == '0) && (sqt_r == '0))

endmodule
